// File: rtl/tmerb_pkg.sv
// ----------------------------------------------------------------------------
// tmerb_pkg: shared types and constants
// Widths, result codes, message bytes and the command and result records
// used by the timed note-event release buffer.
// ----------------------------------------------------------------------------
package tmerb_pkg;

   localparam int DEPTH_DEFAULT = 32;

   localparam int TIME_W   = 40;
   localparam int MS_W     = 30;
   localparam int KEY_W    = 7;
   localparam int VEL_W    = 7;
   localparam int FILL_W   = 7;
   localparam int STATUS_W = 8;
   localparam int KIND_W   = 2;

   localparam logic [VEL_W-1:0]    VELOCITY_RESET  = 7'd80;
   localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [TIME_W-1:0]   US_PER_MS       = 40'd1000;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_REG_VELOCITY = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_RELEASED = 2'd0,
      KIND_ACCEPTED = 2'd1,
      KIND_REFUSED  = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_TICK   = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type      op;
      logic              note_on;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] time_us;
   } cmd_type;

   typedef struct packed {
      kind_type            kind;
      logic [STATUS_W-1:0] status_byte;
      logic [KEY_W-1:0]    note_key;
      logic [VEL_W-1:0]    note_velocity;
      logic [TIME_W-1:0]   release_time_us;
      logic [FILL_W-1:0]   fill_count;
      logic                last;
   } rsp_payload_type;

endpackage

// File: rtl/tmerb_if.sv
// ----------------------------------------------------------------------------
// tmerb channel interfaces
// Valid/ready request and result channels of the note-event release buffer.
// ----------------------------------------------------------------------------
interface tmerb_req_if;
   import tmerb_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic              note_on;
   logic [KEY_W-1:0]  key;
   logic [MS_W-1:0]   event_time_ms;
   logic [TIME_W-1:0] current_time_us;

   modport source (output valid, req_type, note_on, key, event_time_ms, current_time_us,
                   input ready);
   modport sink (input valid, req_type, note_on, key, event_time_ms, current_time_us,
                 output ready);
   modport monitor (input valid, ready, req_type, note_on, key, event_time_ms,
                    current_time_us);
endinterface

interface tmerb_rsp_if;
   import tmerb_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [STATUS_W-1:0] status_byte;
   logic [KEY_W-1:0]    note_key;
   logic [VEL_W-1:0]    note_velocity;
   logic [TIME_W-1:0]   release_time_us;
   logic [FILL_W-1:0]   fill_count;
   logic                last;

   modport source (output valid, kind, status_byte, note_key, note_velocity,
                   release_time_us, fill_count, last, input ready);
   modport sink (input valid, kind, status_byte, note_key, note_velocity,
                 release_time_us, fill_count, last, output ready);
   modport monitor (input valid, ready, kind, status_byte, note_key, note_velocity,
                    release_time_us, fill_count, last);
endinterface

// File: rtl/tmerb_front.sv
// ----------------------------------------------------------------------------
// tmerb_front: request intake
// Accepts requests, classifies them as insert or tick and scales insert times
// from milliseconds to microseconds into one registered command.
// ----------------------------------------------------------------------------
module tmerb_front (
   input  logic               clock,
   input  logic               reset,
   tmerb_req_if.sink          req_ch,
   output logic               cmd_valid,
   output tmerb_pkg::cmd_type cmd,
   input  logic               cmd_ready
);
   import tmerb_pkg::*;

   logic    cmd_v_ff, cmd_v_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req_ch.ready = !cmd_v_ff || cmd_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      cmd_v_in = cmd_v_ff;
      cmd_in   = cmd_ff;
      if (cmd_v_ff && cmd_ready) begin
         cmd_v_in = 1'b0;
      end
      if (accept) begin
         cmd_v_in = 1'b1;
         if (req_ch.req_type == REQ_TICK) begin
            cmd_in.op      = REQ_TICK;
            cmd_in.note_on = 1'b0;
            cmd_in.key     = '0;
            cmd_in.time_us = req_ch.current_time_us;
         end else begin
            cmd_in.op      = REQ_INSERT;
            cmd_in.note_on = req_ch.note_on;
            cmd_in.key     = req_ch.key;
            cmd_in.time_us = TIME_W'(req_ch.event_time_ms) * US_PER_MS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_v_ff <= 1'b0;
      end else begin
         cmd_v_ff <= cmd_v_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_v_ff;
   assign cmd       = cmd_ff;

endmodule

// File: rtl/tmerb_cmd_queue.sv
// ----------------------------------------------------------------------------
// tmerb_cmd_queue: command queue
// Short first-in first-out queue that decouples intake from the slot engine.
// ----------------------------------------------------------------------------
module tmerb_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  tmerb_pkg::cmd_type push_data,
   output logic               push_ready,
   output logic               pop_valid,
   output tmerb_pkg::cmd_type pop_data,
   input  logic               pop_ready
);
   import tmerb_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/tmerb_engine.sv
// ----------------------------------------------------------------------------
// tmerb_engine: slot engine
// Stores inserted events in a slot memory and, on a tick, walks the held slots
// in order, releasing due events and compacting the rest forward.
// ----------------------------------------------------------------------------
module tmerb_engine #(
   parameter int DEPTH = tmerb_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  tmerb_pkg::cmd_type          cmd,
   output logic                        cmd_pop,
   input  logic [tmerb_pkg::VEL_W-1:0] velocity,
   tmerb_rsp_if.source                 rsp_ch
);
   import tmerb_pkg::*;

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [TIME_W-1:0] time_us;
      logic [KEY_W-1:0]  key;
      logic              note_on;
   } slot_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   slot_type mem [DEPTH];

   state_type         state_ff, state_in;
   logic [CntW-1:0]   held_ff, held_in;
   logic [CntW-1:0]   fetch_ff, fetch_in;
   logic [CntW-1:0]   wr_ff, wr_in;
   logic [CntW-1:0]   nrel_ff, nrel_in;
   logic              dv_ff, dv_in;
   slot_type          rdata_ff;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              pend_v_ff, pend_v_in;
   rsp_payload_type   pend_ff, pend_in;
   logic              out_v_ff, out_v_in;
   rsp_payload_type   out_ff, out_in;

   logic              mem_we;
   logic [IdxW-1:0]   mem_waddr;
   slot_type          mem_wdata;
   logic              rd_en;
   logic              out_can_load;
   logic              consume;

   assign out_can_load = !out_v_ff || rsp_ch.ready;

   function automatic rsp_payload_type plain_result(kind_type k, logic [CntW-1:0] fill);
      rsp_payload_type r;
      r                 = '0;
      r.kind            = k;
      r.fill_count      = FILL_W'(fill);
      r.last            = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      fetch_in  = fetch_ff;
      wr_in     = wr_ff;
      nrel_in   = nrel_ff;
      dv_in     = dv_ff;
      now_in    = now_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = held_ff[IdxW-1:0];
      mem_wdata = '0;
      rd_en     = 1'b0;
      consume   = 1'b0;

      if (out_v_ff && rsp_ch.ready) begin
         out_v_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == REQ_TICK) begin
                  cmd_pop   = 1'b1;
                  now_in    = cmd.time_us;
                  fetch_in  = '0;
                  wr_in     = '0;
                  nrel_in   = '0;
                  dv_in     = 1'b0;
                  pend_v_in = 1'b0;
                  state_in  = ST_SCAN;
               end else if (out_can_load) begin
                  cmd_pop  = 1'b1;
                  out_v_in = 1'b1;
                  if (held_ff == CntW'(DEPTH)) begin
                     out_in = plain_result(KIND_REFUSED, held_ff);
                  end else begin
                     mem_we            = 1'b1;
                     mem_waddr         = held_ff[IdxW-1:0];
                     mem_wdata.time_us = cmd.time_us;
                     mem_wdata.key     = cmd.key;
                     mem_wdata.note_on = cmd.note_on;
                     held_in           = held_ff + 1'b1;
                     out_in            = plain_result(KIND_ACCEPTED, held_ff + 1'b1);
                  end
               end
            end
         end
         ST_SCAN: begin
            if (dv_ff) begin
               if (rdata_ff.time_us <= now_ff) begin
                  // previous release goes out once this one proves it was not last
                  if (!pend_v_ff || out_can_load) begin
                     consume = 1'b1;
                     if (pend_v_ff) begin
                        out_v_in = 1'b1;
                        out_in   = pend_ff;
                     end
                     pend_v_in               = 1'b1;
                     pend_in.kind            = KIND_RELEASED;
                     pend_in.status_byte     = rdata_ff.note_on ? STATUS_NOTE_ON
                                                                : STATUS_NOTE_OFF;
                     pend_in.note_key        = rdata_ff.key;
                     pend_in.note_velocity   = velocity;
                     pend_in.release_time_us = rdata_ff.time_us;
                     pend_in.fill_count      = FILL_W'(held_ff - nrel_ff - 1'b1);
                     pend_in.last            = 1'b0;
                     nrel_in                 = nrel_ff + 1'b1;
                  end
               end else begin
                  consume   = 1'b1;
                  mem_we    = 1'b1;
                  mem_waddr = wr_ff[IdxW-1:0];
                  mem_wdata = rdata_ff;
                  wr_in     = wr_ff + 1'b1;
               end
            end
            if (!dv_ff || consume) begin
               if (fetch_ff < held_ff) begin
                  rd_en    = 1'b1;
                  dv_in    = 1'b1;
                  fetch_in = fetch_ff + 1'b1;
               end else begin
                  dv_in = 1'b0;
               end
            end
            if (!dv_ff && !(fetch_ff < held_ff) && out_can_load) begin
               out_v_in = 1'b1;
               if (pend_v_ff) begin
                  out_in      = pend_ff;
                  out_in.last = 1'b1;
               end else begin
                  out_in = plain_result(KIND_NONE, wr_ff);
               end
               pend_v_in = 1'b0;
               held_in   = wr_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         held_ff   <= '0;
         dv_ff     <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         held_ff   <= held_in;
         dv_ff     <= dv_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      fetch_ff <= fetch_in;
      wr_ff    <= wr_in;
      nrel_ff  <= nrel_in;
      now_ff   <= now_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   // slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[fetch_ff[IdxW-1:0]];
      end
   end

   assign rsp_ch.valid           = out_v_ff;
   assign rsp_ch.kind            = out_ff.kind;
   assign rsp_ch.status_byte     = out_ff.status_byte;
   assign rsp_ch.note_key        = out_ff.note_key;
   assign rsp_ch.note_velocity   = out_ff.note_velocity;
   assign rsp_ch.release_time_us = out_ff.release_time_us;
   assign rsp_ch.fill_count      = out_ff.fill_count;
   assign rsp_ch.last            = out_ff.last;

endmodule

// File: rtl/timed_midi_event_release_buffer.sv
// ----------------------------------------------------------------------------
// timed_midi_event_release_buffer: timed note-event release buffer
// Holds up to DEPTH timestamped note events and releases due ones on ticks.
// ----------------------------------------------------------------------------
// An insert request stores a note event (time scaled to microseconds) and is
// answered with one accepted or refused-full result; it passes intake and the
// command queue on its way to the slot engine. A tick request walks the held
// slots through the slot memory, one slot read and one slot write per cycle
// unless the result channel stalls; each due event gives one note message
// result, and a tick with nothing due gives one result. The slot memory needs
// no clearing after reset. The velocity register sits at byte address 0 and
// must only be written while the block is idle.
module timed_midi_event_release_buffer #(
   parameter int DEPTH = tmerb_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   tmerb_req_if.sink                        req_ch,
   tmerb_rsp_if.source                      rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tmerb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tmerb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tmerb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import tmerb_pkg::*;

   logic             front_valid;
   cmd_type          front_cmd;
   logic             front_ready;
   logic             queue_valid;
   cmd_type          queue_cmd;
   logic             queue_pop;
   logic [VEL_W-1:0] velocity_ff, velocity_in;
   logic             csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_REG_VELOCITY);
   assign csr_prdata = csr_hit ? CSR_DATA_W'(velocity_ff) : '0;

   always_comb begin
      velocity_in = velocity_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         velocity_in = csr_pwdata[VEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_ff <= VELOCITY_RESET;
      end else begin
         velocity_ff <= velocity_in;
      end
   end

   tmerb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   tmerb_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_cmd),
      .push_ready (front_ready),
      .pop_valid  (queue_valid),
      .pop_data   (queue_cmd),
      .pop_ready  (queue_pop)
   );

   tmerb_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .velocity  (velocity_ff),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: rtl/tmerb_checker.sv
// ----------------------------------------------------------------------------
// tmerb_checker: port-level checks
// Concurrent checks on the result channel of the release buffer.
// ----------------------------------------------------------------------------
module tmerb_checker #(
   parameter int DEPTH = tmerb_pkg::DEPTH_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tmerb_pkg::KIND_W-1:0]   rsp_kind,
   input logic [tmerb_pkg::STATUS_W-1:0] rsp_status_byte,
   input logic [tmerb_pkg::FILL_W-1:0]   rsp_fill_count,
   input logic                           rsp_last
);
   import tmerb_pkg::*;

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_fill_count) && $stable(rsp_last))
      else $error("result changed while stalled");

   // insert answers and empty ticks are always single results
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_RELEASED) |-> rsp_last)
      else $error("non-release result without last");

   // released events carry a note on or note off status
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_RELEASED) |->
         (rsp_status_byte == STATUS_NOTE_ON) || (rsp_status_byte == STATUS_NOTE_OFF))
      else $error("bad status byte on release");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill_count <= FILL_W'(DEPTH)))
      else $error("fill count above depth");
endmodule

bind timed_midi_event_release_buffer tmerb_checker #(
   .DEPTH (DEPTH)
) u_tmerb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_kind        (rsp_ch.kind),
   .rsp_status_byte (rsp_ch.status_byte),
   .rsp_fill_count  (rsp_ch.fill_count),
   .rsp_last        (rsp_ch.last)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: note-event release buffer testbench
// Streams insert and tick requests through the request channel with random
// gaps and result stalls, tracks the held events in a local scoreboard copy of
// the buffer and checks every result in order. The velocity register is
// reprogrammed between traffic phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import tmerb_pkg::*;

   localparam int BUF_DEPTH      = DEPTH_DEFAULT;
   localparam int SPARE_REG      = 1;
   localparam logic [CSR_ADDR_W-1:0] VELOCITY_ADDR = CSR_ADDR_W'(4 * CSR_REG_VELOCITY);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR    = CSR_ADDR_W'(4 * SPARE_REG);
   localparam logic [MS_W-1:0] MS_MAX = '1;
   localparam int PRESSURE_PHASE = 2;
   localparam int HOLD_CYCLES    = 500;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = BUF_DEPTH + 16;
   localparam int REPORT_MAX     = 10;

   typedef struct packed {
      req_kind_type      op;
      logic              note_on;
      logic [KEY_W-1:0]  key;
      logic [MS_W-1:0]   event_ms;
      logic [TIME_W-1:0] now_us;
   } note_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tmerb_req_if req_ch();
   tmerb_rsp_if rsp_ch();

   timed_midi_event_release_buffer #(
      .DEPTH(BUF_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scoreboard copy of the buffer
   logic [TIME_W-1:0] sched_time [BUF_DEPTH];
   logic [KEY_W-1:0]  sched_key  [BUF_DEPTH];
   logic              sched_on   [BUF_DEPTH];
   int unsigned       sched_count = 0;
   logic [VEL_W-1:0]  velocity_reg = VELOCITY_RESET;

   rsp_payload_type note_results[$];
   note_item_type   pending_notes[$];

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned mismatch_count = 0;
   logic [TIME_W-1:0] stim_now_us = '0;

   bit idle_enable = 1'b1;
   int phase_no    = 0;
   int req_gap, rsp_gap, hold_left;
   bit hold_done;
   logic req_taken;

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("mismatch: %s", msg);
   endtask

   task automatic push_result(input kind_type kind, input logic [STATUS_W-1:0] status,
                              input logic [KEY_W-1:0] key, input logic [VEL_W-1:0] vel,
                              input logic [TIME_W-1:0] t, input int unsigned fill,
                              input logic last);
      rsp_payload_type r;
      r.kind            = kind;
      r.status_byte     = status;
      r.note_key        = key;
      r.note_velocity   = vel;
      r.release_time_us = t;
      r.fill_count      = FILL_W'(fill);
      r.last            = last;
      note_results.push_back(r);
   endtask

   // insert stores the event, tick releases due events in order and compacts
   task automatic schedule_step(input note_item_type it);
      int unsigned due_total, released, wr;
      if (it.op == REQ_INSERT) begin
         if (sched_count >= BUF_DEPTH) begin
            push_result(KIND_REFUSED, '0, '0, '0, '0, sched_count, 1'b1);
         end else begin
            sched_on[sched_count]   = it.note_on;
            sched_key[sched_count]  = it.key;
            sched_time[sched_count] = TIME_W'(it.event_ms) * US_PER_MS;
            sched_count++;
            push_result(KIND_ACCEPTED, '0, '0, '0, '0, sched_count, 1'b1);
         end
      end else begin
         due_total = 0;
         for (int rd = 0; rd < sched_count; rd++)
            if (sched_time[rd] <= it.now_us) due_total++;
         released = 0;
         wr = 0;
         for (int rd = 0; rd < sched_count; rd++) begin
            if (sched_time[rd] <= it.now_us) begin
               push_result(KIND_RELEASED, sched_on[rd] ? STATUS_NOTE_ON : STATUS_NOTE_OFF,
                           sched_key[rd], velocity_reg, sched_time[rd],
                           sched_count - released - 1, released == due_total - 1);
               released++;
            end else begin
               sched_time[wr] = sched_time[rd];
               sched_key[wr]  = sched_key[rd];
               sched_on[wr]   = sched_on[rd];
               wr++;
            end
         end
         sched_count = wr;
         if (due_total == 0)
            push_result(KIND_NONE, '0, '0, '0, '0, sched_count, 1'b1);
      end
   endtask

   task automatic queue_item(input req_kind_type op, input logic on,
                             input logic [KEY_W-1:0] key, input logic [MS_W-1:0] ms,
                             input logic [TIME_W-1:0] now);
      note_item_type it;
      it.op       = op;
      it.note_on  = on;
      it.key      = key;
      it.event_ms = ms;
      it.now_us   = now;
      pending_notes.push_back(it);
      queued_count++;
   endtask

   // fill past capacity first, then mostly near-term inserts and advancing ticks
   task automatic queue_random_traffic(input int unsigned count);
      int unsigned mode, base_ms;
      base_ms = 32'(stim_now_us / 1000);
      for (int k = 0; k < BUF_DEPTH + 2; k++)
         queue_item(REQ_INSERT, 1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 127)),
                    MS_W'(base_ms + $urandom_range(0, 60)), TIME_W'({$urandom, $urandom}));
      for (int k = 0; k < count; k++) begin
         mode    = $urandom_range(0, 99);
         base_ms = 32'(stim_now_us / 1000);
         if (mode < 45) begin
            queue_item(REQ_INSERT, 1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 127)),
                       MS_W'(base_ms + $urandom_range(0, 40)),
                       TIME_W'({$urandom, $urandom}));
         end else if (mode < 85) begin
            stim_now_us = stim_now_us + TIME_W'($urandom_range(0, 20000));
            queue_item(REQ_TICK, 1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 127)),
                       MS_W'($urandom), stim_now_us);
         end else if (mode < 93) begin
            queue_item(REQ_INSERT, 1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 127)),
                       MS_W'($urandom), TIME_W'({$urandom, $urandom}));
         end else begin
            queue_item(REQ_TICK, 1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 127)),
                       MS_W'($urandom), TIME_W'({$urandom, $urandom}));
         end
      end
   endtask

   task automatic csr_cycle(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (wr && addr == VELOCITY_ADDR)
         velocity_reg = wdata[VEL_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_register(input logic [CSR_ADDR_W-1:0] addr,
                                   input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_cycle(1'b1, addr, value, readback);
      csr_cycle(1'b0, VELOCITY_ADDR, '0, readback);
      if (readback !== CSR_DATA_W'(velocity_reg))
         flag_mismatch($sformatf("velocity readback expected %0d got %0d",
                                 velocity_reg, readback));
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (accepted_count != queued_count || note_results.size() != 0);
   endtask

   // request driver
   always @(negedge clock) begin
      note_item_type nxt;
      if (reset) begin
         req_ch.valid           <= 1'b0;
         req_ch.req_type        <= REQ_INSERT;
         req_ch.note_on         <= 1'b0;
         req_ch.key             <= '0;
         req_ch.event_time_ms   <= '0;
         req_ch.current_time_us <= '0;
         req_gap                <= 0;
      end else if (!req_ch.valid || req_taken) begin
         if (idle_enable && req_gap != 0) begin
            req_gap      <= req_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            req_gap      <= $urandom_range(0, 17);
            req_ch.valid <= 1'b0;
         end else if (pending_notes.size() != 0) begin
            nxt = pending_notes.pop_front();
            req_ch.req_type        <= nxt.op;
            req_ch.note_on         <= nxt.note_on;
            req_ch.key             <= nxt.key;
            req_ch.event_time_ms   <= nxt.event_ms;
            req_ch.current_time_us <= nxt.now_us;
            req_ch.valid           <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // long result hold-off so the block backs up into its request side
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (phase_no == PRESSURE_PHASE && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap      <= 0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
      end else if (!idle_enable) begin
         rsp_gap      <= 0;
         rsp_ch.ready <= 1'b1;
      end else if (rsp_gap != 0) begin
         rsp_gap      <= rsp_gap - 1;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_gap      <= $urandom_range(0, 17);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      note_item_type   seen;
      rsp_payload_type got, want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind            = kind_type'(rsp_ch.kind);
            got.status_byte     = rsp_ch.status_byte;
            got.note_key        = rsp_ch.note_key;
            got.note_velocity   = rsp_ch.note_velocity;
            got.release_time_us = rsp_ch.release_time_us;
            got.fill_count      = rsp_ch.fill_count;
            got.last            = rsp_ch.last;
            if (note_results.size() == 0) begin
               flag_mismatch($sformatf("unexpected result kind %0d key %0d fill %0d",
                                       got.kind, got.note_key, got.fill_count));
            end else begin
               want = note_results.pop_front();
               if (got !== want)
                  flag_mismatch($sformatf(
                     {"expected kind %0d st %h key %0d vel %0d t %0d fill %0d last %0d, ",
                      "got kind %0d st %h key %0d vel %0d t %0d fill %0d last %0d"},
                     want.kind, want.status_byte, want.note_key, want.note_velocity,
                     want.release_time_us, want.fill_count, want.last,
                     got.kind, got.status_byte, got.note_key, got.note_velocity,
                     got.release_time_us, got.fill_count, got.last));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.op       = req_kind_type'(req_ch.req_type);
            seen.note_on  = req_ch.note_on;
            seen.key      = req_ch.key;
            seen.event_ms = req_ch.event_time_ms;
            seen.now_us   = req_ch.current_time_us;
            schedule_step(seen);
            accepted_count++;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: reset velocity, edge times, ignored fields, ordered compaction
      @(posedge clock);
      phase_no = 1;
      queue_item(REQ_TICK,   1'b0, 7'd0,   '0,     40'd0);
      queue_item(REQ_INSERT, 1'b1, 7'd0,   '0,     '1);
      queue_item(REQ_INSERT, 1'b0, 7'd127, MS_MAX, '0);
      queue_item(REQ_INSERT, 1'b1, 7'd60,  30'd5,  40'h55_5555_5555);
      queue_item(REQ_INSERT, 1'b0, 7'd61,  30'd5,  '0);
      queue_item(REQ_TICK,   1'b1, 7'd127, MS_MAX, 40'd4999);
      queue_item(REQ_TICK,   1'b0, 7'd0,   '0,     40'd5000);
      queue_item(REQ_TICK,   1'b0, 7'd0,   '0,     40'd1073741822999);
      queue_item(REQ_TICK,   1'b1, 7'd127, MS_MAX, '1);
      queue_item(REQ_TICK,   1'b0, 7'd0,   '0,     '1);
      queue_item(REQ_INSERT, 1'b1, 7'd10,  30'd10,   '0);
      queue_item(REQ_INSERT, 1'b0, 7'd11,  30'd1000, '0);
      queue_item(REQ_INSERT, 1'b1, 7'd12,  30'd10,   '0);
      queue_item(REQ_INSERT, 1'b0, 7'd13,  30'd2000, '0);
      queue_item(REQ_TICK,   1'b0, 7'd0,   '0,     40'd10000);
      queue_item(REQ_TICK,   1'b0, 7'd0,   '0,     40'd1500000);
      queue_item(REQ_TICK,   1'b0, 7'd0,   '0,     40'd2000000);
      stim_now_us = 40'd2000000;

      wait_quiet();
      program_register(VELOCITY_ADDR, {25'($urandom_range(0, 32'h1FF_FFFF)), 7'd127});
      @(posedge clock);
      phase_no = PRESSURE_PHASE;
      queue_random_traffic(115);

      wait_quiet();
      program_register(VELOCITY_ADDR, 32'd0);
      program_register(SPARE_ADDR, 32'h7F);
      @(posedge clock);
      phase_no = 3;
      queue_random_traffic(115);

      wait_quiet();
      program_register(VELOCITY_ADDR, CSR_DATA_W'($urandom_range(1, 126)));
      @(posedge clock);
      phase_no    = 4;
      idle_enable = 1'b0;
      queue_random_traffic(115);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && note_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
